// ----- src/sha224_pkg.sv -----
// Shared definitions for the SHA-224 stream hash: round constants, initial
// chaining value, sequencing constants and the control and status structs.
// No dependencies.
package sha224_pkg;

  localparam int LENGTH_BITS_DEF = 61;
  localparam int BLOCK_WORDS = 16;
  localparam int STATE_WORDS = 8;
  localparam int DIGEST_WORDS = 7;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS = 7'd56;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);

  localparam logic [31:0] INIT_CHAIN [STATE_WORDS] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic        byte_we;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_val;
    logic        len_we;
    logic [63:0] len_bits;
    logic        start;
    logic        chain_init;
  } sha224_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha224_stat_t;

endpackage

// ----- src/sha224_core.sv -----
// SHA-224 compression core: block buffer used as the rolling schedule window,
// one shared round unit stepped through the 64 rounds, and the chaining value.
// Depends on sha224_pkg.
module sha224_core (
  input  logic                    clk,
  input  logic                    rst,
  input  sha224_pkg::sha224_ctrl_t ctrl,
  output sha224_pkg::sha224_stat_t stat,
  output logic [31:0]             chain_value [sha224_pkg::STATE_WORDS]
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } core_state_t;

  core_state_t state;
  logic [5:0]  round_count;
  logic        done;
  logic [31:0] window [sha224_pkg::BLOCK_WORDS];
  logic [31:0] work [sha224_pkg::STATE_WORDS];

  logic [31:0] w_next;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    if (round_count[5:4] == 2'b00) begin
      w_next = window[0];
    end else begin
      w_next = window[0]
             + (rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3))
             + window[9]
             + (rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10));
    end
    t1 = work[7]
       + (rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25))
       + ((work[4] & work[5]) ^ (~work[4] & work[6]))
       + sha224_pkg::ROUND_K[round_count]
       + w_next;
    t2 = (rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22))
       + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      round_count <= '0;
      done <= 1'b0;
      for (int i = 0; i < sha224_pkg::STATE_WORDS; i++) begin
        chain_value[i] <= sha224_pkg::INIT_CHAIN[i];
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (ctrl.chain_init) begin
            for (int i = 0; i < sha224_pkg::STATE_WORDS; i++) begin
              chain_value[i] <= sha224_pkg::INIT_CHAIN[i];
            end
          end
          if (ctrl.start) begin
            for (int i = 0; i < sha224_pkg::STATE_WORDS; i++) begin
              work[i] <= chain_value[i];
            end
            round_count <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          work[7] <= work[6];
          work[6] <= work[5];
          work[5] <= work[4];
          work[4] <= work[3] + t1;
          work[3] <= work[2];
          work[2] <= work[1];
          work[1] <= work[0];
          work[0] <= t1 + t2;
          round_count <= round_count + 6'd1;
          if (round_count == sha224_pkg::LAST_ROUND) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < sha224_pkg::STATE_WORDS; i++) begin
            chain_value[i] <= chain_value[i] + work[i];
          end
          done <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_ROUND) begin
      for (int i = 0; i < sha224_pkg::BLOCK_WORDS - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[sha224_pkg::BLOCK_WORDS - 1] <= w_next;
    end else begin
      if (ctrl.byte_we) begin
        case (ctrl.byte_pos[1:0])
          2'd0:    window[ctrl.byte_pos[5:2]][31:24] <= ctrl.byte_val;
          2'd1:    window[ctrl.byte_pos[5:2]][23:16] <= ctrl.byte_val;
          2'd2:    window[ctrl.byte_pos[5:2]][15:8] <= ctrl.byte_val;
          default: window[ctrl.byte_pos[5:2]][7:0] <= ctrl.byte_val;
        endcase
      end
      if (ctrl.len_we) begin
        window[14] <= ctrl.len_bits[63:32];
        window[15] <= ctrl.len_bits[31:0];
      end
    end
  end

  assign stat.busy = (state != C_IDLE);
  assign stat.done = done;

endmodule

// ----- src/sha224_stream_hash.sv -----
// SHA-224 stream hash top level: byte intake, padding sequencer and digest
// output. Depends on sha224_pkg and sha224_core.
//
// Message bytes enter on the slave channel, one per transaction: s_tdata is
// the byte, s_tuser says whether a byte is present and s_tlast ends the
// message after this transaction's byte. The digest leaves on the master
// channel as seven transactions, most significant word first, with m_tlast
// on the seventh.
// A byte is taken whenever the slave channel is ready. When it completes a
// 64-byte block the channel is held off while the shared round unit runs its
// 64 rounds and the chaining value is updated. At the end of a message the
// padding is written one byte per cycle, and the last step writes the length
// and starts the final compression. When the marker lands at byte 56 or
// beyond, the rest of that block is zero-filled and compressed first.
// While the digest is being delivered no input is taken, and a stall on
// m_tready simply holds the current word. After the last word is taken the
// chaining value and byte count return to their initial values.
// Reset discards any partial message and restores the initial state.
module sha224_stream_hash #(
  parameter int LENGTH_BITS = sha224_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast    // last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLOCK,
    S_PAD_MARK,
    S_PAD_TAIL,
    S_TAIL_WAIT,
    S_PAD_ZERO,
    S_FINAL_WAIT,
    S_OUT
  } top_state_t;

  top_state_t               state;
  logic [LENGTH_BITS-1:0]   count;
  logic                     eom_pend;
  logic [6:0]               pad_pos;
  logic [2:0]               out_idx;
  logic [39:0]              out_data;

  sha224_pkg::sha224_ctrl_t ctrl;
  sha224_pkg::sha224_stat_t stat;
  logic [31:0]              chain_value [sha224_pkg::STATE_WORDS];

  logic in_acc;
  logic out_acc;
  logic byte_in;
  logic block_full;

  assign in_acc = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign byte_in = in_acc && s_tuser;
  assign block_full = (count[5:0] == 6'h3f);

  always_comb begin
    ctrl = '0;
    ctrl.len_bits = 64'({count, 3'b000});
    unique case (state)
      S_IDLE: begin
        ctrl.byte_we = byte_in;
        ctrl.byte_pos = count[5:0];
        ctrl.byte_val = s_tdata;
        ctrl.start = byte_in && block_full;
      end
      S_PAD_MARK: begin
        ctrl.byte_we = 1'b1;
        ctrl.byte_pos = pad_pos[5:0];
        ctrl.byte_val = sha224_pkg::PAD_BYTE;
      end
      S_PAD_TAIL: begin
        ctrl.byte_we = (pad_pos != sha224_pkg::BLOCK_BYTES);
        ctrl.byte_pos = pad_pos[5:0];
        ctrl.start = (pad_pos == sha224_pkg::BLOCK_BYTES);
      end
      S_PAD_ZERO: begin
        ctrl.byte_we = (pad_pos != sha224_pkg::LEN_POS);
        ctrl.byte_pos = pad_pos[5:0];
        ctrl.len_we = (pad_pos == sha224_pkg::LEN_POS);
        ctrl.start = (pad_pos == sha224_pkg::LEN_POS);
      end
      S_OUT: begin
        ctrl.chain_init = out_acc && (out_idx == sha224_pkg::LAST_WORD_IDX);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      eom_pend <= 1'b0;
      pad_pos <= '0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            eom_pend <= s_tlast;
            pad_pos <= {1'b0, count[5:0]} + 7'(s_tuser);
            if (s_tuser) begin
              count <= count + 1'b1;
            end
            if (s_tuser && block_full) begin
              state <= S_BLOCK;
            end else if (s_tlast) begin
              state <= S_PAD_MARK;
            end
          end
        end
        S_BLOCK: begin
          if (stat.done) begin
            pad_pos <= '0;
            state <= eom_pend ? S_PAD_MARK : S_IDLE;
          end
        end
        S_PAD_MARK: begin
          pad_pos <= pad_pos + 7'd1;
          state <= (pad_pos + 7'd1 > sha224_pkg::LEN_POS) ? S_PAD_TAIL : S_PAD_ZERO;
        end
        S_PAD_TAIL: begin
          if (pad_pos == sha224_pkg::BLOCK_BYTES) begin
            state <= S_TAIL_WAIT;
          end else begin
            pad_pos <= pad_pos + 7'd1;
          end
        end
        S_TAIL_WAIT: begin
          if (stat.done) begin
            pad_pos <= '0;
            state <= S_PAD_ZERO;
          end
        end
        S_PAD_ZERO: begin
          if (pad_pos == sha224_pkg::LEN_POS) begin
            state <= S_FINAL_WAIT;
          end else begin
            pad_pos <= pad_pos + 7'd1;
          end
        end
        S_FINAL_WAIT: begin
          if (stat.done) begin
            out_idx <= '0;
            out_data <= {5'b0, 3'd0, chain_value[0]};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (out_idx == sha224_pkg::LAST_WORD_IDX) begin
              count <= '0;
              eom_pend <= 1'b0;
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
              out_data <= {5'b0, out_idx + 3'd1, chain_value[out_idx + 3'd1]};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha224_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .chain_value (chain_value)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = out_data;
  assign m_tlast = (out_idx == sha224_pkg::LAST_WORD_IDX);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output channels active together");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[34:32] == sha224_pkg::LAST_WORD_IDX))
    else $error("last digest word carries the wrong index");

  a_core_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !s_tready)
    else $error("input accepted while the round unit is busy");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && count == '0))
    else $error("block not reinitialised after the digest");

endmodule

// ----- test/tb_sha224_stream_hash.sv -----
// Self-checking testbench for sha224_stream_hash: message bytes are streamed in
// with random gaps, and each digest word is checked against a SHA-224 model.
// Depends on sha224_pkg and the sha224_stream_hash RTL.
module tb_sha224_stream_hash;

  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  logic [31:0] hash_state [sha224_pkg::STATE_WORDS];
  logic [31:0] msg_block [sha224_pkg::BLOCK_WORDS];
  logic [sha224_pkg::LENGTH_BITS_DEF-1:0] byte_count;
  digest_word_t pending_digest [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  bit  no_gaps = 1'b0;

  sha224_stream_hash DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void put_msg_byte(input logic [5:0] pos, input logic [7:0] value);
    msg_block[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = value;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, s0, s1, ch, maj, t1, t2, w15, w2;
    for (int i = 0; i < sha224_pkg::STATE_WORDS; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = msg_block[t];
      end else begin
        w15 = w[(t - 15) & 15];
        w2 = w[(t - 2) & 15];
        s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
      end
      w[t & 15] = wt;
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sha224_pkg::ROUND_K[t] + wt;
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < sha224_pkg::STATE_WORDS; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void absorb_item(input logic [7:0] value, input logic present,
                                      input logic ends);
    logic [6:0]  pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    if (present) begin
      put_msg_byte(byte_count[5:0], value);
      byte_count = byte_count + 1'b1;
      if (byte_count[5:0] == 6'd0) compress_block();
    end
    if (!ends) return;
    pos = {1'b0, byte_count[5:0]};
    put_msg_byte(pos[5:0], sha224_pkg::PAD_BYTE);
    pos = pos + 1'b1;
    if (pos > sha224_pkg::LEN_POS) begin
      while (pos < sha224_pkg::BLOCK_BYTES) begin
        put_msg_byte(pos[5:0], 8'h00);
        pos = pos + 1'b1;
      end
      compress_block();
      pos = 7'd0;
    end
    while (pos < sha224_pkg::LEN_POS) begin
      put_msg_byte(pos[5:0], 8'h00);
      pos = pos + 1'b1;
    end
    bit_len = {byte_count, 3'b000};
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < sha224_pkg::DIGEST_WORDS; i++) begin
      dw.word = hash_state[i];
      dw.index = 3'(i);
      dw.last = (3'(i) == sha224_pkg::LAST_WORD_IDX);
      pending_digest.push_back(dw);
    end
    hash_state = sha224_pkg::INIT_CHAIN;
    byte_count = '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("unexpected digest word", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_digest.pop_front();
        if (m_tdata[31:0] !== want.word) report_mismatch("digest_word", m_tdata[31:0], want.word);
        if (m_tdata[34:32] !== want.index) begin
          report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(want.index));
        end
        if (m_tlast !== want.last) report_mismatch("last_word", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Valid stays high from one transaction to the next unless a gap is drawn.
  task automatic send_item(input logic [7:0] value, input logic present, input logic ends);
    while (!no_gaps && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= present;
    s_tlast <= ends;
    do @(posedge clk); while (!s_tready);
    absorb_item(value, present, ends);
    if (present) bytes_sent++;
  endtask

  task automatic send_message(input int n_bytes, input bit end_alone);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        sent++;
        send_item(8'($urandom_range(0, 255)), 1'b1, (sent == n_bytes) && !end_alone);
      end
    end
    if (end_alone || n_bytes == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_single_bytes();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
  endtask

  task automatic test_ignored_items();
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h3c, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_short_text();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // Lengths around the padding boundary come first, then mostly short
  // messages with the occasional one that needs an extra padding block.
  task automatic test_random_messages();
    int boundary_len [3];
    int n_msgs;
    boundary_len = '{55, 56, 64};
    n_msgs = 0;
    bytes_sent = 0;
    while (bytes_sent < 160 || n_msgs < 4) begin
      no_gaps = (n_msgs == 2);
      if (n_msgs < 3) begin
        send_message(boundary_len[n_msgs], $urandom_range(0, 3) == 0);
      end else if ($urandom_range(0, 3) == 0) begin
        send_message($urandom_range(56, 63), $urandom_range(0, 3) == 0);
      end else begin
        send_message($urandom_range(0, 40), $urandom_range(0, 3) == 0);
      end
      n_msgs++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    hash_state = sha224_pkg::INIT_CHAIN;
    byte_count = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_single_bytes();
    test_ignored_items();
    test_short_text();
    test_random_messages();
    s_tvalid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
